// ===== rtl/ptt_pkg.sv =====
// Shared types and constants for the periodic timer table.
// Used by ptt_ctrl, ptt_datapath and periodic_timer_table; no dependencies.
package ptt_pkg;

	localparam int SLOTS      = 16;
	localparam int TIME_BITS  = 40;
	localparam int SLOT_W     = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W      = $clog2(SLOTS + 1);
	localparam int PERIOD_W   = 24;
	localparam int KEEP_W     = 16;
	localparam int US_PER_MS  = 1000;
	localparam int MS_MUL_W   = 10;
	localparam int ID_W       = 4;
	localparam int ACT_W      = 5;

	// operation codes on the input side
	localparam logic OP_REGISTER = 1'b0;
	localparam logic OP_TICK     = 1'b1;

	// tdata layouts
	localparam int IN_TDATA_W  = 88;
	localparam int OUT_TDATA_W = 16;

	typedef enum logic [1:0] {
		KIND_REGISTERED = 2'd0,
		KIND_FULL       = 2'd1,
		KIND_FIRED      = 2'd2,
		KIND_QUIET      = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_REG,
		ST_SCAN,
		ST_EMIT
	} state_t;

	// controller -> datapath
	typedef struct packed {
		logic load_in;    // latch the accepted input item, rewind scan
		logic do_reg;     // perform register, load its result
		logic scan_step;  // evaluate the slot at the scan index
		logic emit;       // load next tick result into the output register
	} ptt_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic is_tick;    // latched item is a tick
		logic out_free;   // output register can take a result this cycle
		logic scan_done;  // scan index is at the last slot
		logic one_left;   // at most one pending fired slot remains
	} ptt_sts_t;

endpackage

// ===== rtl/ptt_ctrl.sv =====
// Controller state machine of the periodic timer table.
// Depends on ptt_pkg; drives ptt_datapath through ptt_cmd_t.
module ptt_ctrl import ptt_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	output logic     in_ready,
	input  ptt_sts_t sts,
	output ptt_cmd_t cmd
);

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_REG;
			end
			ST_REG: begin
				if (sts.is_tick) state_d = ST_SCAN;
				else if (sts.out_free) state_d = ST_IDLE;
			end
			ST_SCAN: begin
				if (sts.scan_done) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (sts.out_free && sts.one_left) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready    = 1'b1;
				cmd.load_in = in_valid;
			end
			ST_REG: begin
				cmd.do_reg = !sts.is_tick && sts.out_free;
			end
			ST_SCAN: begin
				cmd.scan_step = 1'b1;
			end
			ST_EMIT: begin
				cmd.emit = sts.out_free;
			end
			default: ;
		endcase
	end

endmodule

// ===== rtl/ptt_datapath.sv =====
// Datapath of the periodic timer table: input latch, slot store, scan unit,
// result buffer and output register. Depends on ptt_pkg.
module ptt_datapath import ptt_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  ptt_cmd_t             cmd,
	output ptt_sts_t             sts,
	input  logic                 in_op,
	input  logic [TIME_BITS-1:0] in_now_us,
	input  logic [PERIOD_W-1:0]  in_period_ms,
	input  logic                 in_one_shot,
	input  logic [KEEP_W-1:0]    in_keep_mask,
	input  logic                 out_ready,
	output logic                 out_valid,
	output kind_t                out_kind,
	output logic [ID_W-1:0]      out_slot_id,
	output logic                 out_retired,
	output logic [ACT_W-1:0]     out_active_count,
	output logic                 out_last
);

	// latched input item
	logic                 op_q;
	logic [TIME_BITS-1:0] now_q;
	logic [PERIOD_W-1:0]  period_ms_q;
	logic                 one_shot_q;
	logic [SLOTS-1:0]     keep_q;

	// slot store
	logic [SLOTS-1:0]     valid_q;
	logic                 slot_one_shot_q [SLOTS];
	logic [TIME_BITS-1:0] slot_period_q   [SLOTS];
	logic [TIME_BITS-1:0] slot_last_q     [SLOTS];
	logic [CNT_W-1:0]     count_q;

	// scan and result buffer
	logic [SLOT_W-1:0]    idx_q;
	logic [SLOTS-1:0]     pend_q;
	logic [SLOTS-1:0]     ret_q;

	// output register
	logic                 out_valid_q;
	kind_t                out_kind_q;
	logic [ID_W-1:0]      out_slot_q;
	logic                 out_ret_q;
	logic [ACT_W-1:0]     out_cnt_q;
	logic                 out_last_q;

	logic                 out_free;
	logic                 free_any;
	logic [SLOT_W-1:0]    free_idx;
	logic [SLOT_W-1:0]    pend_idx;
	logic [PERIOD_W+MS_MUL_W-1:0] period_prod;
	logic [TIME_BITS-1:0] period_us;
	logic [TIME_BITS-1:0] elapsed;
	logic                 fire;
	logic                 retire;
	logic [SLOTS-1:0]     pend_rest;

	assign out_free = !out_valid_q || out_ready;

	// lowest free slot
	always_comb begin
		free_any = 1'b0;
		free_idx = '0;
		for (int j = SLOTS - 1; j >= 0; j--) begin
			if (!valid_q[j]) begin
				free_any = 1'b1;
				free_idx = SLOT_W'(j);
			end
		end
	end

	// lowest pending fired slot
	always_comb begin
		pend_idx = '0;
		for (int j = SLOTS - 1; j >= 0; j--) begin
			if (pend_q[j]) pend_idx = SLOT_W'(j);
		end
	end

	assign pend_rest   = pend_q & (pend_q - SLOTS'(1));
	assign period_prod = period_ms_q * MS_MUL_W'(US_PER_MS);
	assign period_us   = TIME_BITS'(period_prod);

	assign elapsed = now_q - slot_last_q[idx_q];
	assign fire    = valid_q[idx_q] && (elapsed >= slot_period_q[idx_q]);
	assign retire  = slot_one_shot_q[idx_q] || !keep_q[idx_q];

	always_comb begin
		sts.is_tick   = (op_q == OP_TICK);
		sts.out_free  = out_free;
		sts.scan_done = (idx_q == SLOT_W'(SLOTS - 1));
		sts.one_left  = (pend_rest == '0);
	end

	// input latch
	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			now_q       <= in_now_us;
			period_ms_q <= in_period_ms;
			one_shot_q  <= in_one_shot;
			keep_q      <= SLOTS'(in_keep_mask);
		end
	end

	// slot payload, one write port
	always_ff @(posedge clk) begin
		if (cmd.do_reg && free_any) begin
			slot_one_shot_q[free_idx] <= one_shot_q;
			slot_period_q[free_idx]   <= period_us;
			slot_last_q[free_idx]     <= now_q;
		end else if (cmd.scan_step && fire && !retire) begin
			slot_last_q[idx_q] <= now_q;
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q    <= OP_REGISTER;
			valid_q <= '0;
			count_q <= '0;
			idx_q   <= '0;
			pend_q  <= '0;
			ret_q   <= '0;
		end else begin
			if (cmd.load_in) begin
				op_q   <= in_op;
				idx_q  <= '0;
				pend_q <= '0;
				ret_q  <= '0;
			end
			if (cmd.do_reg && free_any) begin
				valid_q[free_idx] <= 1'b1;
				count_q           <= CNT_W'(count_q + 1'b1);
			end
			if (cmd.scan_step) begin
				idx_q <= SLOT_W'(idx_q + 1'b1);
				if (fire) begin
					pend_q[idx_q] <= 1'b1;
					ret_q[idx_q]  <= retire;
					if (retire) begin
						valid_q[idx_q] <= 1'b0;
						count_q        <= CNT_W'(count_q - 1'b1);
					end
				end
			end
			if (cmd.emit) begin
				pend_q[pend_idx] <= 1'b0;
				ret_q[pend_idx]  <= 1'b0;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.do_reg || cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.do_reg) begin
			out_kind_q <= free_any ? KIND_REGISTERED : KIND_FULL;
			out_slot_q <= free_any ? ID_W'(free_idx) : '0;
			out_ret_q  <= 1'b0;
			out_cnt_q  <= free_any ? ACT_W'(count_q + 1'b1) : ACT_W'(count_q);
			out_last_q <= 1'b1;
		end else if (cmd.emit) begin
			out_kind_q <= (pend_q == '0) ? KIND_QUIET : KIND_FIRED;
			out_slot_q <= ID_W'(pend_idx);
			out_ret_q  <= ret_q[pend_idx];
			out_cnt_q  <= ACT_W'(count_q);
			out_last_q <= (pend_rest == '0);
		end
	end

	assign out_valid        = out_valid_q;
	assign out_kind         = out_kind_q;
	assign out_slot_id      = out_slot_q;
	assign out_retired      = out_ret_q;
	assign out_active_count = out_cnt_q;
	assign out_last         = out_last_q;

	a_count_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == 32'(count_q))
		else $error("active count out of step with valid bits");

	a_retired_is_pending: assert property (@(posedge clk) disable iff (!arst_n)
		(ret_q & ~pend_q) == '0)
		else $error("retired flag without pending fired slot");

	a_scan_clears_fired: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.scan_step && fire && retire) |=> !valid_q[$past(idx_q)])
		else $error("retired slot still valid after scan");

endmodule

// ===== rtl/periodic_timer_table.sv =====
// Periodic timer table, top level: handshake ports, controller and datapath.
// Register item: accepted in ST_IDLE, then its single result is loaded in ST_REG.
// Tick item: accepted in ST_IDLE, decoded in ST_REG, then ST_SCAN sweeps every slot (one slot
// per cycle through one subtract and compare), then its results leave the output register
// one per cycle while it is free. A held-off output register stretches either path.
// Reset (arst_n low, asynchronous): all slots invalid, count zero, no result pending.
// Depends on ptt_pkg, ptt_ctrl and ptt_datapath.
module periodic_timer_table import ptt_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	// input stream
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // now_us[39:0], period_ms[63:40],
	                                              // one_shot[64], keep_mask[80:65], zero pad
	input  logic                   s_axis_tuser,  // operation
	// result stream
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata,  // slot_id[3:0], retired[4],
	                                              // active_count[9:5], zero pad
	output logic [1:0]             m_axis_tuser,  // kind
	output logic                   m_axis_tlast   // final result of the item
);

	ptt_cmd_t         cmd;
	ptt_sts_t         sts;
	kind_t            kind;
	logic [ID_W-1:0]  slot_id;
	logic             retired;
	logic [ACT_W-1:0] active_count;

	// The controller sequences one item at a time: the register path loads its
	// result in ST_REG; the tick path sweeps every slot, then drains the fired list.
	ptt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Field unpacking from tdata, lowest field in the lowest bits.
	ptt_datapath u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.in_op            (s_axis_tuser),
		.in_now_us        (s_axis_tdata[TIME_BITS-1:0]),
		.in_period_ms     (s_axis_tdata[TIME_BITS+PERIOD_W-1:TIME_BITS]),
		.in_one_shot      (s_axis_tdata[TIME_BITS+PERIOD_W]),
		.in_keep_mask     (s_axis_tdata[TIME_BITS+PERIOD_W+KEEP_W:TIME_BITS+PERIOD_W+1]),
		.out_ready        (m_axis_tready),
		.out_valid        (m_axis_tvalid),
		.out_kind         (kind),
		.out_slot_id      (slot_id),
		.out_retired      (retired),
		.out_active_count (active_count),
		.out_last         (m_axis_tlast)
	);

	// Result packing; upper tdata bits are zero fill.
	assign m_axis_tuser = kind;
	assign m_axis_tdata = OUT_TDATA_W'({active_count, retired, slot_id});

endmodule

// ===== dv/tb_periodic_timer_table.sv =====
// Testbench for periodic_timer_table: directed and random register/tick transfers,
// checked against a behavioral timer table kept inside the bench.
// Depends on ptt_pkg and the periodic_timer_table RTL.
module tb_periodic_timer_table;
	import ptt_pkg::*;

	localparam int HOLD_CYCLES = 300;   // long receiver hold-off, fills the block
	localparam int TAIL_CYCLES = 60;    // settle time after the last result
	localparam int PRINT_LIMIT = 40;

	typedef struct packed {
		kind_t      kind;
		logic [3:0] slot;
		logic       retired;
		logic [4:0] active;
		logic       last;
	} timer_event_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;
	logic                   s_axis_tuser = OP_REGISTER;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;
	logic [1:0]             m_axis_tuser;
	logic                   m_axis_tlast;

	// bench copy of the timer table
	bit        slot_live  [16];
	bit        slot_once  [16];
	bit [39:0] slot_period[16];
	bit [39:0] slot_stamp [16];

	timer_event_t expected_events[$];
	int           mismatches = 0;
	bit           pacing_on = 1'b1;   // random gaps on both sides
	bit           hold_req = 1'b0;    // receiver hold-off request
	int           stall_left = 0;
	bit [39:0]    wall_us = '0;       // running time for well-formed traffic

	periodic_timer_table i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	always #10 clk = ~clk;

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(12, 50);
	endfunction

	// Timer table update for one item; queues the results it yields.
	function automatic void predict_timer_events(input logic op, input logic [39:0] now,
			input logic [23:0] period_ms, input logic once, input logic [15:0] keep);
		timer_event_t evs[$];
		timer_event_t ev;
		int           free_slot;
		int           live;
		bit [39:0]    elapsed;
		bit           retire;
		free_slot = -1;
		live = 0;
		ev = '0;
		if (op == OP_REGISTER) begin
			for (int i = 15; i >= 0; i--)
				if (!slot_live[i])
					free_slot = i;
			if (free_slot >= 0) begin
				slot_live[free_slot]   = 1'b1;
				slot_once[free_slot]   = once;
				slot_period[free_slot] = 40'(period_ms) * 40'd1000;
				slot_stamp[free_slot]  = now;
				ev.kind = KIND_REGISTERED;
				ev.slot = 4'(free_slot);
			end else begin
				ev.kind = KIND_FULL;
			end
			evs.push_back(ev);
		end else begin
			for (int i = 0; i < 16; i++) begin
				if (!slot_live[i])
					continue;
				elapsed = now - slot_stamp[i];
				if (elapsed < slot_period[i])
					continue;
				retire = slot_once[i] || !keep[i];
				if (retire)
					slot_live[i] = 1'b0;
				else
					slot_stamp[i] = now;
				ev.kind    = KIND_FIRED;
				ev.slot    = 4'(i);
				ev.retired = retire;
				evs.push_back(ev);
			end
			if (evs.size() == 0) begin
				ev.kind = KIND_QUIET;
				evs.push_back(ev);
			end
		end
		foreach (slot_live[i])
			live += slot_live[i];
		foreach (evs[k]) begin
			evs[k].active = 5'(live);
			evs[k].last   = (k == evs.size() - 1);
			expected_events.push_back(evs[k]);
		end
	endfunction

	task automatic report_mismatch(input string what, input longint unsigned got,
			input longint unsigned want_v);
		if (mismatches < PRINT_LIMIT)
			$display("[%0t] mismatch %s: got %0h, expected %0h", $realtime, what, got, want_v);
		mismatches++;
	endtask

	// Offer one item and hold it until the transfer; valid stays high for a
	// following item unless a gap is taken.
	task automatic send_item(input logic op, input logic [39:0] now,
			input logic [23:0] period_ms, input logic once, input logic [15:0] keep);
		int gap;
		if (pacing_on && $urandom_range(0, 99) < 35) begin
			gap = pick_gap();
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= op;
		s_axis_tdata  <= {7'b0, keep, once, period_ms, now};
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		predict_timer_events(op, now, period_ms, once, keep);
	endtask

	task automatic send_register(input logic [39:0] now, input logic [23:0] period_ms,
			input logic once);
		send_item(OP_REGISTER, now, period_ms, once, 16'($urandom()));
	endtask

	task automatic send_tick(input logic [39:0] now, input logic [15:0] keep);
		send_item(OP_TICK, now, 24'($urandom()), 1'($urandom()), keep);
	endtask

	// sender pause: nothing offered until every pending result is out
	task automatic wait_for_results();
		s_axis_tvalid <= 1'b0;
		do
			@(posedge clk);
		while (expected_events.size() != 0);
	endtask

	// Result side: random stalls, plus one long hold-off when requested.
	initial begin
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_axis_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end else if (stall_left > 0) begin
				m_axis_tready <= 1'b0;
				stall_left--;
			end else begin
				m_axis_tready <= 1'b1;
				if (pacing_on && $urandom_range(0, 99) < 20)
					stall_left = pick_gap();
			end
		end
	end

	// Compare each result transfer with the oldest pending expectation.
	always @(posedge clk) begin : result_check
		timer_event_t want;
		if (m_axis_tvalid && m_axis_tready) begin
			if (expected_events.size() == 0) begin
				report_mismatch("unexpected result, kind", m_axis_tuser, 0);
			end else begin
				want = expected_events.pop_front();
				if (m_axis_tuser !== want.kind)
					report_mismatch("kind", m_axis_tuser, want.kind);
				if (m_axis_tdata[3:0] !== want.slot)
					report_mismatch("slot_id", m_axis_tdata[3:0], want.slot);
				if (m_axis_tdata[4] !== want.retired)
					report_mismatch("retired", m_axis_tdata[4], want.retired);
				if (m_axis_tdata[9:5] !== want.active)
					report_mismatch("active_count", m_axis_tdata[9:5], want.active);
				if (m_axis_tlast !== want.last)
					report_mismatch("last", m_axis_tlast, want.last);
			end
		end
	end

	// empty table, then a tick that finds nothing due
	task automatic test_quiet_tick();
		send_tick(40'd0, 16'hFFFF);
	endtask

	// zero and full-scale periods, time wrap, keep mask all set and all clear
	task automatic test_period_extremes();
		send_register(40'hFF_FFFF_FFFF, 24'd0, 1'b0);
		send_register(40'd0, 24'hFF_FFFF, 1'b1);
		send_tick(40'd5, 16'hFFFF);          // zero period fires across the wrap, kept
		send_tick(40'd6, 16'hFFFF);          // nothing else due yet for the long one
		send_tick(40'hFF_FFFF_FFFF, 16'h0);  // both fire and retire
	endtask

	// back-to-back, no gaps: fill all slots, one more is refused, then a mass expiry
	task automatic test_fill_and_full();
		pacing_on = 1'b0;
		for (int i = 0; i < 16; i++)
			send_register(40'd1000, 24'(i % 3), i[0]);
		send_register(40'd1000, 24'd7, 1'b0);
		send_tick(40'd4000, 16'hA5A5);
		wall_us = 40'd4000;
		pacing_on = 1'b1;
	endtask

	// receiver holds off while ticks keep coming, so the block fills and stalls
	task automatic test_backpressure_fill();
		wait_for_results();
		hold_req = 1'b1;
		for (int i = 0; i < 4; i++)
			send_register(wall_us, 24'd0, 1'b0);
		for (int i = 0; i < 8; i++) begin
			wall_us += 40'd100;
			send_tick(wall_us, 16'hFFFF);
		end
		wait_for_results();
	endtask

	// Mostly well-formed traffic on a running clock with short periods,
	// the rest full-range noise. Pauses now and then until drained.
	task automatic test_random_traffic(input int count);
		logic [39:0] noise_now;
		for (int n = 0; n < count; n++) begin
			noise_now = 40'({$urandom(), $urandom()});
			if ($urandom_range(0, 99) < 82) begin
				if ($urandom_range(0, 99) < 42) begin
					send_register(wall_us, 24'($urandom_range(0, 25)),
						$urandom_range(0, 3) == 0);
				end else begin
					wall_us += 40'($urandom_range(0, 30000));
					send_tick(wall_us, 16'($urandom() | $urandom()));
				end
			end else if ($urandom_range(0, 1) == 0) begin
				send_register(noise_now, 24'($urandom()), 1'($urandom()));
			end else begin
				send_tick(noise_now, 16'($urandom()));
			end
			if (n % 60 == 59)
				wait_for_results();
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_quiet_tick();
		test_period_extremes();
		test_fill_and_full();
		test_backpressure_fill();
		test_random_traffic(245);
		wait_for_results();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

	// run limit, far beyond the slowest legal run
	initial begin
		#30_000_000;
		$display("== FAIL ==");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/ptt_pkg.sv
rtl/ptt_ctrl.sv
rtl/ptt_datapath.sv
rtl/periodic_timer_table.sv
dv/tb_periodic_timer_table.sv
